FILE: rtl/tob_pkg.sv
// ----------------------------------------------------------------------------
// tob_pkg
// shared constants, codes and types of the ohlcv bar builder
// ----------------------------------------------------------------------------
package tob_pkg;

   localparam int BAR_DEPTH   = 1024;
   localparam int IDX_W       = $clog2(BAR_DEPTH);
   localparam int CNT_W       = $clog2(BAR_DEPTH + 1);

   localparam int TIME_W      = 48;
   localparam int PRICE_W     = 32;
   localparam int VOL_W       = 48;
   localparam int LEN_W       = 40;
   localparam int BAR_INDEX_W = 10;
   localparam int STATUS_W    = 2;
   localparam int OSEL_W      = 2;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;

   localparam int DIV_CNT_W   = $clog2(TIME_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TIME_W - 1);

   localparam logic [LEN_W-1:0] BAR_LENGTH_RESET = LEN_W'(60000);

   // register select is paddr bit 3 (registers sit 8 bytes apart)
   localparam logic CSR_SEL_BAR_LENGTH = 1'b0;
   localparam logic CSR_SEL_FIRST_START = 1'b1;

   localparam logic KIND_PRICE  = 1'b0;
   localparam logic KIND_VOLUME = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_APPLIED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_BAR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   localparam logic [OSEL_W-1:0] OSEL_DROP   = 2'd0;
   localparam logic [OSEL_W-1:0] OSEL_UPDATE = 2'd1;
   localparam logic [OSEL_W-1:0] OSEL_NEW    = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0]  start;
      logic [PRICE_W-1:0] open;
      logic [PRICE_W-1:0] high;
      logic [PRICE_W-1:0] low;
      logic [PRICE_W-1:0] close;
      logic [VOL_W-1:0]   volume;
   } bar_type;

   typedef struct packed {
      logic                load;
      logic                scan;
      logic                fetch;
      logic                div_init;
      logic                div_step;
      logic                ns_first;
      logic                ns_div;
      logic                write_new;
      logic                write_upd;
      logic                out_load;
      logic [OSEL_W-1:0]   out_sel;
      logic [STATUS_W-1:0] drop_status;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic is_volume;
      logic cnt_zero;
      logic late;
      logic full;
      logic div_done;
      logic slot_free;
   } sts_type;

   typedef struct packed {
      logic [BAR_INDEX_W-1:0] bar_index;
      logic [TIME_W-1:0]      start_time;
      logic [PRICE_W-1:0]     open_price;
      logic [PRICE_W-1:0]     high_price;
      logic [PRICE_W-1:0]     low_price;
      logic [PRICE_W-1:0]     close_price;
      logic [VOL_W-1:0]       volume_sum;
      logic                   created;
      logic [STATUS_W-1:0]    status;
   } rsp_type;

endpackage

FILE: rtl/tob_if.sv
// ----------------------------------------------------------------------------
// tob_if
// valid/ready channels for tick beats and bar result beats
// ----------------------------------------------------------------------------
interface tob_req_if import tob_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [TIME_W-1:0]  tick_time;
   logic [PRICE_W-1:0] tick_value;

   modport source (output valid, kind, tick_time, tick_value, input ready);
   modport sink   (input valid, kind, tick_time, tick_value, output ready);
endinterface

interface tob_rsp_if import tob_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [BAR_INDEX_W-1:0] bar_index;
   logic [TIME_W-1:0]      start_time;
   logic [PRICE_W-1:0]     open_price;
   logic [PRICE_W-1:0]     high_price;
   logic [PRICE_W-1:0]     low_price;
   logic [PRICE_W-1:0]     close_price;
   logic [VOL_W-1:0]       volume_sum;
   logic                   created;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, bar_index, start_time, open_price, high_price,
                   low_price, close_price, volume_sum, created, status,
                   input ready);
   modport sink   (input valid, bar_index, start_time, open_price, high_price,
                   low_price, close_price, volume_sum, created, status,
                   output ready);
endinterface

FILE: rtl/tob_csr.sv
// ----------------------------------------------------------------------------
// tob_csr
// apb register file: bar length and first bar start
// ----------------------------------------------------------------------------
module tob_csr import tob_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LEN_W-1:0]      bar_length,
   output logic [TIME_W-1:0]     first_bar_start
);

   logic [LEN_W-1:0]  bar_length_ff;
   logic [TIME_W-1:0] first_start_ff;
   logic              wr_en;
   logic              sel;

   assign sel   = csr_paddr[3];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         bar_length_ff  <= BAR_LENGTH_RESET;
         first_start_ff <= '0;
      end else if (wr_en) begin
         unique case (sel)
            CSR_SEL_BAR_LENGTH:  bar_length_ff  <= csr_pwdata[LEN_W-1:0];
            CSR_SEL_FIRST_START: first_start_ff <= csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         CSR_SEL_BAR_LENGTH:  csr_prdata = CSR_DATA_W'(bar_length_ff);
         CSR_SEL_FIRST_START: csr_prdata = CSR_DATA_W'(first_start_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign csr_pready      = 1'b1;
   assign bar_length      = bar_length_ff;
   assign first_bar_start = first_start_ff;

endmodule

FILE: rtl/tob_ctrl.sv
// ----------------------------------------------------------------------------
// tob_ctrl
// sequencer: scan, decide, align divide, update or create, result load
// ----------------------------------------------------------------------------
module tob_ctrl import tob_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_NSET   = 3'd4;
   localparam logic [2:0] ST_NEW    = 3'd5;
   localparam logic [2:0] ST_UPD    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.found) begin
               cmd.fetch = 1'b1;
               state_in  = ST_UPD;
            end else if (sts.is_volume || (!sts.cnt_zero && sts.late)) begin
               if (sts.slot_free) begin
                  cmd.out_load    = 1'b1;
                  cmd.out_sel     = OSEL_DROP;
                  cmd.drop_status = STATUS_NO_BAR;
                  state_in        = ST_IDLE;
               end
            end else if (sts.full) begin
               if (sts.slot_free) begin
                  cmd.out_load    = 1'b1;
                  cmd.out_sel     = OSEL_DROP;
                  cmd.drop_status = STATUS_FULL;
                  state_in        = ST_IDLE;
               end
            end else if (sts.cnt_zero) begin
               cmd.ns_first = 1'b1;
               state_in     = ST_NEW;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_NSET;
            end
         end
         ST_NSET: begin
            cmd.ns_div = 1'b1;
            state_in   = ST_NEW;
         end
         ST_NEW: begin
            if (sts.slot_free) begin
               cmd.write_new = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_sel   = OSEL_NEW;
               state_in      = ST_IDLE;
            end
         end
         ST_UPD: begin
            if (sts.slot_free) begin
               cmd.write_upd = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_sel   = OSEL_UPDATE;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tob_dpath.sv
// ----------------------------------------------------------------------------
// tob_dpath
// bar memory, window scan compare, remainder divider, result register
// ----------------------------------------------------------------------------
module tob_dpath import tob_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               kind,
   input  logic [TIME_W-1:0]  tick_time,
   input  logic [PRICE_W-1:0] tick_value,
   input  logic [LEN_W-1:0]   bar_length,
   input  logic [TIME_W-1:0]  first_bar_start,
   output rsp_type            rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   bar_type mem [BAR_DEPTH];

   logic               kind_ff;
   logic [TIME_W-1:0]  t_ff;
   logic [PRICE_W-1:0] v_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   raddr_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   bar_type            rd_data_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   hit_ff;
   logic [TIME_W-1:0]  ls_ff;
   logic [TIME_W-1:0]  diff_ff;
   logic [LEN_W-1:0]   rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [TIME_W-1:0]  ns_ff;
   rsp_type            rsp_ff;
   logic               rsp_vld_ff;

   logic [LEN_W-1:0]   len_eff;
   logic               scan_go;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               hit_now;
   logic [TIME_W:0]    win_end;
   logic [TIME_W:0]    last_end;
   logic [LEN_W:0]     trial;
   logic [LEN_W-1:0]   rem_in;
   logic [VOL_W:0]     vol_sum;
   bar_type            upd_bar;
   bar_type            new_bar;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   bar_type            wr_data;
   rsp_type            rsp_in;

   assign len_eff = (bar_length == '0) ? LEN_W'(1) : bar_length;

   // window scan, one entry per cycle
   assign scan_go = cmd.scan && (raddr_ff < cnt_ff);
   assign rd_en   = scan_go || cmd.fetch;
   assign rd_addr = cmd.fetch ? hit_ff : raddr_ff[IDX_W-1:0];

   assign win_end  = {1'b0, rd_data_ff.start} + (TIME_W+1)'(len_ff);
   assign last_end = {1'b0, ls_ff} + (TIME_W+1)'(len_ff);
   assign hit_now  = rd_vld_ff && (rd_data_ff.start <= t_ff) && ({1'b0, t_ff} < win_end);

   // restoring remainder step, one quotient bit per cycle
   assign trial  = {rem_ff, diff_ff[TIME_W-1]};
   assign rem_in = (trial >= {1'b0, len_ff}) ? LEN_W'(trial - {1'b0, len_ff})
                                             : trial[LEN_W-1:0];

   // bar update
   assign vol_sum = {1'b0, rd_data_ff.volume} + (VOL_W+1)'(v_ff);
   always_comb begin
      upd_bar = rd_data_ff;
      if (kind_ff == KIND_VOLUME) begin
         upd_bar.volume = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
      end else begin
         if (v_ff > rd_data_ff.high) begin
            upd_bar.high = v_ff;
         end
         if (v_ff < rd_data_ff.low) begin
            upd_bar.low = v_ff;
         end
         upd_bar.close = v_ff;
      end
   end

   assign new_bar = '{start: ns_ff, open: v_ff, high: v_ff, low: v_ff, close: v_ff,
                      volume: '0};

   assign wr_en   = cmd.write_new || cmd.write_upd;
   assign wr_addr = cmd.write_new ? cnt_ff[IDX_W-1:0] : hit_ff;
   assign wr_data = cmd.write_new ? new_bar : upd_bar;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (cmd.out_sel)
         OSEL_UPDATE: begin
            rsp_in.bar_index   = BAR_INDEX_W'(hit_ff);
            rsp_in.start_time  = upd_bar.start;
            rsp_in.open_price  = upd_bar.open;
            rsp_in.high_price  = upd_bar.high;
            rsp_in.low_price   = upd_bar.low;
            rsp_in.close_price = upd_bar.close;
            rsp_in.volume_sum  = upd_bar.volume;
            rsp_in.status      = STATUS_APPLIED;
         end
         OSEL_NEW: begin
            rsp_in.bar_index   = BAR_INDEX_W'(cnt_ff[IDX_W-1:0]);
            rsp_in.start_time  = new_bar.start;
            rsp_in.open_price  = new_bar.open;
            rsp_in.high_price  = new_bar.high;
            rsp_in.low_price   = new_bar.low;
            rsp_in.close_price = new_bar.close;
            rsp_in.volume_sum  = new_bar.volume;
            rsp_in.created     = 1'b1;
            rsp_in.status      = STATUS_APPLIED;
         end
         default: rsp_in.status = cmd.drop_status;
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind;
         t_ff    <= tick_time;
         v_ff    <= tick_value;
         len_ff  <= len_eff;
      end
      if (scan_go) begin
         rd_idx_ff <= raddr_ff[IDX_W-1:0];
      end
      if (rd_vld_ff) begin
         ls_ff <= rd_data_ff.start;
      end
      if (hit_now) begin
         hit_ff <= rd_idx_ff;
      end
      if (cmd.div_init) begin
         diff_ff    <= t_ff - ls_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         diff_ff    <= {diff_ff[TIME_W-2:0], 1'b0};
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.ns_first) begin
         ns_ff <= first_bar_start;
      end else if (cmd.ns_div) begin
         ns_ff <= t_ff - TIME_W'(rem_ff);
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         raddr_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            raddr_ff  <= '0;
            rd_vld_ff <= 1'b0;
            found_ff  <= 1'b0;
         end else begin
            rd_vld_ff <= scan_go;
            if (scan_go) begin
               raddr_ff <= raddr_ff + 1'b1;
            end
            if (hit_now) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.write_new) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign sts.scan_done = (raddr_ff >= cnt_ff) && !rd_vld_ff;
   assign sts.found     = found_ff;
   assign sts.is_volume = (kind_ff == KIND_VOLUME);
   assign sts.cnt_zero  = (cnt_ff == '0);
   assign sts.late      = ({1'b0, t_ff} < last_end);
   assign sts.full      = (cnt_ff >= CNT_W'(BAR_DEPTH));
   assign sts.div_done  = (div_cnt_ff == DIV_LAST);
   assign sts.slot_free = !rsp_vld_ff || rsp_ready;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_vld_ff;

endmodule

FILE: rtl/tick_to_ohlcv_bar_builder.sv
// ----------------------------------------------------------------------------
// tick_to_ohlcv_bar_builder
// builds a table of time bars (start, open, high, low, close, volume) from ticks
// ----------------------------------------------------------------------------
// usage
//   req_bus carries one tick per beat: kind (price or volume), time, value
//   rsp_bus returns exactly one beat per tick describing the affected bar,
//   or a dropped status with all bar fields zero
//   csr port sets bar length (addr 0x0) and first bar start (addr 0x8)
// tick processing
//   one tick at a time; the scan reads the bar memory one entry per cycle,
//   and the remainder divider runs when a new bar is aligned past the last one
// reset
//   bar table empties (count to zero), registers return to 60000 and 0,
//   no clearing pass: entries past the count are never read
// stall
//   the result sits in an output register; a new tick is taken while it
//   waits, and the next result waits only if the register is still full
// ----------------------------------------------------------------------------
module tick_to_ohlcv_bar_builder import tob_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tob_req_if.sink               req_bus,
   tob_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEN_W-1:0]  bar_length;
   logic [TIME_W-1:0] first_bar_start;
   cmd_type           cmd;
   sts_type           sts;
   rsp_type           rsp_data;

   tob_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .bar_length      (bar_length),
      .first_bar_start (first_bar_start)
   );

   // sequencer
   tob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // bar memory and arithmetic
   tob_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .kind            (req_bus.kind),
      .tick_time       (req_bus.tick_time),
      .tick_value      (req_bus.tick_value),
      .bar_length      (bar_length),
      .first_bar_start (first_bar_start),
      .rsp_data        (rsp_data),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready)
   );

   assign rsp_bus.bar_index   = rsp_data.bar_index;
   assign rsp_bus.start_time  = rsp_data.start_time;
   assign rsp_bus.open_price  = rsp_data.open_price;
   assign rsp_bus.high_price  = rsp_data.high_price;
   assign rsp_bus.low_price   = rsp_data.low_price;
   assign rsp_bus.close_price = rsp_data.close_price;
   assign rsp_bus.volume_sum  = rsp_data.volume_sum;
   assign rsp_bus.created     = rsp_data.created;
   assign rsp_bus.status      = rsp_data.status;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tick to ohlcv bar builder: a scoreboard keeps
// its own bar table, predicts one result beat per tick beat and compares it
// field by field; random idling on both channels, several bar lengths,
// and a run of one-unit bars near the top of the time range
// ----------------------------------------------------------------------------
module tb_top import tob_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned TIME_MAX   = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned LEN_MAX    = 64'hFF_FFFF_FFFF;
   localparam longint unsigned CYCLE_CAP  = 64'd4_000_000;
   localparam int              DRAIN_WAIT = 1200;
   localparam int              TOP_BARS   = 100;

   // bar table mirror and queue of expected result beats
   class bar_scoreboard;
      longint unsigned bar_len;
      longint unsigned first_start;
      longint unsigned starts [BAR_DEPTH];
      logic [PRICE_W-1:0] opens [BAR_DEPTH];
      logic [PRICE_W-1:0] highs [BAR_DEPTH];
      logic [PRICE_W-1:0] lows  [BAR_DEPTH];
      logic [PRICE_W-1:0] closes[BAR_DEPTH];
      longint unsigned vols  [BAR_DEPTH];
      int unsigned bar_total;
      rsp_type expected_bars[$];
      int errors;

      function new();
         bar_len     = 60000;
         first_start = 0;
         bar_total   = 0;
         errors      = 0;
      endfunction

      function longint unsigned eff_len();
         return (bar_len == 0) ? 1 : bar_len;
      endfunction

      function void queue_beat(rsp_type r);
         expected_bars.insert(expected_bars.size(), r);
      endfunction

      function rsp_type bar_beat(int unsigned idx, logic made);
         rsp_type r;
         r.bar_index   = idx[BAR_INDEX_W-1:0];
         r.start_time  = starts[idx][TIME_W-1:0];
         r.open_price  = opens[idx];
         r.high_price  = highs[idx];
         r.low_price   = lows[idx];
         r.close_price = closes[idx];
         r.volume_sum  = vols[idx][VOL_W-1:0];
         r.created     = made;
         r.status      = STATUS_APPLIED;
         return r;
      endfunction

      // accepted tick beat: update the mirror and queue the expected beat
      function void note_tick(logic kind, longint unsigned t, logic [PRICE_W-1:0] v);
         longint unsigned len, ls, ns, sum;
         int unsigned hit;
         bit found;
         rsp_type drop;
         len   = eff_len();
         found = 0;
         hit   = 0;
         drop  = '0;
         for (int unsigned n = 0; n < bar_total; n++)
            if (starts[n] <= t && t < starts[n] + len) begin
               hit = n;
               found = 1;
            end
         if (kind == KIND_VOLUME) begin
            if (!found) begin
               drop.status = STATUS_NO_BAR;
               queue_beat(drop);
               return;
            end
            sum = vols[hit] + longint'(v);
            if (sum > TIME_MAX) sum = TIME_MAX;
            vols[hit] = sum;
            queue_beat(bar_beat(hit, 1'b0));
            return;
         end
         if (!found) begin
            if (bar_total == 0) begin
               ns = first_start;
            end else begin
               ls = starts[bar_total-1];
               if (t < ls + len) begin
                  drop.status = STATUS_NO_BAR;
                  queue_beat(drop);
                  return;
               end
               ns = ls + ((t - ls) / len) * len;
            end
            if (bar_total >= BAR_DEPTH) begin
               drop.status = STATUS_FULL;
               queue_beat(drop);
               return;
            end
            hit = bar_total;
            starts[hit] = ns & TIME_MAX;
            opens[hit]  = v;
            highs[hit]  = v;
            lows[hit]   = v;
            closes[hit] = v;
            vols[hit]   = 0;
            bar_total++;
            queue_beat(bar_beat(hit, 1'b1));
            return;
         end
         if (v > highs[hit]) highs[hit] = v;
         if (v < lows[hit]) lows[hit] = v;
         closes[hit] = v;
         queue_beat(bar_beat(hit, 1'b0));
      endfunction

      function void check_beat(rsp_type got);
         rsp_type exp;
         if (expected_bars.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
         end
         exp = expected_bars.pop_front();
         if (got.bar_index !== exp.bar_index) begin
            $error("bar_index exp %0d got %0d", exp.bar_index, got.bar_index); errors++;
         end
         if (got.start_time !== exp.start_time) begin
            $error("start_time exp %0h got %0h", exp.start_time, got.start_time); errors++;
         end
         if (got.open_price !== exp.open_price) begin
            $error("open_price exp %0h got %0h", exp.open_price, got.open_price); errors++;
         end
         if (got.high_price !== exp.high_price) begin
            $error("high_price exp %0h got %0h", exp.high_price, got.high_price); errors++;
         end
         if (got.low_price !== exp.low_price) begin
            $error("low_price exp %0h got %0h", exp.low_price, got.low_price); errors++;
         end
         if (got.close_price !== exp.close_price) begin
            $error("close_price exp %0h got %0h", exp.close_price, got.close_price);
            errors++;
         end
         if (got.volume_sum !== exp.volume_sum) begin
            $error("volume_sum exp %0h got %0h", exp.volume_sum, got.volume_sum); errors++;
         end
         if (got.created !== exp.created) begin
            $error("created exp %0d got %0d", exp.created, got.created); errors++;
         end
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tob_req_if req_bus();
   tob_rsp_if rsp_bus();

   bar_scoreboard bars;
   longint unsigned cycle_count = 0;
   bit fast_mode;   // no idling on either side while set
   bit rsp_run;

   tick_to_ohlcv_bar_builder uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // result beats are checked where valid and ready meet
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.bar_index   = rsp_bus.bar_index;
         got.start_time  = rsp_bus.start_time;
         got.open_price  = rsp_bus.open_price;
         got.high_price  = rsp_bus.high_price;
         got.low_price   = rsp_bus.low_price;
         got.close_price = rsp_bus.close_price;
         got.volume_sum  = rsp_bus.volume_sum;
         got.created     = rsp_bus.created;
         got.status      = rsp_bus.status;
         bars.check_beat(got);
      end
   end

   // receiver: a random stall, possibly none, before every result beat
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      wait (rsp_run);
      forever begin
         n = fast_mode ? 0 : $urandom_range(0, 16);
         if (n > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // apb register write (setup, then access), called at a falling edge
   task automatic csr_write(logic sel, longint unsigned value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {sel, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (sel == CSR_SEL_BAR_LENGTH) bars.bar_len = value & LEN_MAX;
      else bars.first_start = value & TIME_MAX;
   endtask

   // one tick beat: random gap, then hold valid until accepted
   task automatic send_tick(logic kind, longint unsigned t, logic [PRICE_W-1:0] v);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind       = kind;
      req_bus.tick_time  = t[TIME_W-1:0];
      req_bus.tick_value = v;
      req_bus.valid      = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      bars.note_tick(kind, t & TIME_MAX, v);
      @(negedge clock);
   endtask

   // wait for every expected beat, then let the block settle
   task automatic drain();
      req_bus.valid = 1'b0;
      while (bars.expected_bars.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic longint unsigned rand48();
      return {$urandom, $urandom} & TIME_MAX;
   endfunction

   function automatic logic [PRICE_W-1:0] rand_value();
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return '0;
      if (c == 1) return '1;
      return $urandom;
   endfunction

   // mostly ticks inside known bars or just past the last one, some noise
   task automatic random_ticks(int count);
      longint unsigned len, t, ls;
      logic kind;
      int c;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) fast_mode = ~fast_mode;
         len  = bars.eff_len();
         kind = ($urandom_range(0, 99) < 30) ? KIND_VOLUME : KIND_PRICE;
         c    = $urandom_range(0, 99);
         if (bars.bar_total == 0) begin
            t = $urandom_range(0, 100000);
         end else begin
            ls = bars.starts[bars.bar_total-1];
            if (c < 65)
               t = bars.starts[$urandom_range(0, bars.bar_total-1)] + rand48() % len;
            else if (c < 85)
               t = ls + len * $urandom_range(1, 3) + rand48() % len;
            else
               t = rand48() % (ls + len);
         end
         send_tick(kind, t, rand_value());
      end
      fast_mode = 1'b0;
   endtask

   initial begin
      longint unsigned t;
      fast_mode     = 1'b0;
      rsp_run       = 1'b0;
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_PRICE;
      req_bus.tick_time  = '0;
      req_bus.tick_value = '0;
      bars = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset   = 1'b0;
      rsp_run = 1'b1;

      // first bar lands on the configured start, whatever the tick time
      csr_write(CSR_SEL_FIRST_START, 12345);
      csr_write(CSR_SEL_BAR_LENGTH, 60000);

      // directed: empty table, extremes of value, gaps between bars
      send_tick(KIND_VOLUME, 0, 5);                // volume on empty table
      send_tick(KIND_PRICE, 0, 1000);              // first bar
      send_tick(KIND_PRICE, 100, 900);             // before the first bar
      send_tick(KIND_PRICE, 20000, 32'hFFFF_FFFF); // new high
      send_tick(KIND_PRICE, 20001, 0);             // new low
      send_tick(KIND_VOLUME, 30000, 32'hFFFF_FFFF);
      send_tick(KIND_VOLUME, 72344, 1);            // last unit of the window
      send_tick(KIND_PRICE, 72345, 500);           // next window, back to back
      send_tick(KIND_PRICE, 1000000, 7);           // aligned past a gap
      send_tick(KIND_VOLUME, 200000, 3);           // inside the gap
      send_tick(KIND_PRICE, 200000, 3);            // late price in the gap
      send_tick(KIND_VOLUME, 1000000, 123);
      send_tick(KIND_PRICE, 1000001, 32'h8000_0000);
      drain();

      // zero length acts as one
      csr_write(CSR_SEL_BAR_LENGTH, 0);
      random_ticks(140);
      drain();

      csr_write(CSR_SEL_BAR_LENGTH, $urandom_range(1, 5000));
      random_ticks(150);
      drain();

      // widest bars, only a few ticks so time stays in range
      csr_write(CSR_SEL_BAR_LENGTH, LEN_MAX);
      random_ticks(12);
      drain();

      csr_write(CSR_SEL_BAR_LENGTH, $urandom_range(1, 1 << 24));
      random_ticks(150);
      drain();

      // has no effect now that the table holds bars
      csr_write(CSR_SEL_FIRST_START, TIME_MAX);

      // a run of one-unit bars near the top of the time range
      csr_write(CSR_SEL_BAR_LENGTH, 1);
      t = TIME_MAX - 5000;
      for (int i = 0; i < TOP_BARS; i++) begin
         send_tick(KIND_PRICE, t, rand_value());
         t = t + $urandom_range(1, 4);
      end
      send_tick(KIND_PRICE, TIME_MAX, 77);         // bar at the last time unit
      send_tick(KIND_PRICE, bars.starts[bars.bar_total-1], 1);
      send_tick(KIND_VOLUME, bars.starts[0], 32'hFFFF_FFFF);
      send_tick(KIND_PRICE, 5, 9);                 // far too early
      drain();

      csr_write(CSR_SEL_BAR_LENGTH, LEN_MAX);
      send_tick(KIND_PRICE, TIME_MAX, 32'hFFFF_FFFF);
      send_tick(KIND_VOLUME, TIME_MAX, 32'h5555_5555);
      random_ticks(10);
      drain();

      if (bars.errors == 0 && bars.expected_bars.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tob_pkg.sv
rtl/tob_if.sv
rtl/tob_csr.sv
rtl/tob_ctrl.sv
rtl/tob_dpath.sv
rtl/tick_to_ohlcv_bar_builder.sv
bench/tb_top.sv
